// ----- rtl/mmc_pkg.sv -----
// Shared constants and types of the magnetometer min/max calibration block.
// Used by every module of the block; depends on nothing else.

package mmc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 12;

	// Configuration port: one 32-bit register, byte address = 4 * index
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_CALIB_ENABLE = 1'b0;

	localparam logic [1:0] AXIS_FIRST = 2'd0;
	localparam logic [1:0] AXIS_LAST  = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic       accept;   // take the input item
		logic       setup;    // prepare the divider for the current axis
		logic       step;     // one quotient bit
		logic       store;    // write the current axis result
		logic       publish;  // move working results to the output register
		logic [1:0] axis;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic span_zero;  // current axis has max at or below min
		logic div_last;   // last quotient bit in this cycle
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

// ----- rtl/mmc_ifs.sv -----
// Valid/ready channel interfaces for samples in and normalized results out.
// Depends on mmc_pkg for the default sample width.

interface mmc_smp_if #(
	parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_x;
	logic [SAMPLE_BITS-1:0] raw_y;
	logic [SAMPLE_BITS-1:0] raw_z;

	modport source (output valid, raw_x, raw_y, raw_z, input ready);
	modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface mmc_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] norm_x;
	logic signed [31:0] norm_y;
	logic signed [31:0] norm_z;
	logic               in_calibration;
	logic               zero_span;

	modport source (output valid, norm_x, norm_y, norm_z, in_calibration, zero_span,
		input ready);
	modport sink   (input valid, norm_x, norm_y, norm_z, in_calibration, zero_span,
		output ready);
endinterface

// ----- rtl/magnetometer_minmax_calibrate_normalize_unit.sv -----
// Magnetometer hard-iron min/max calibration and normalization, top level.
// Holds the configuration register and joins mmc_ctrl and mmc_dpath.
// Depends on mmc_pkg and the channel interfaces in mmc_ifs.sv.
//
// Usage: one sample item (raw_x, raw_y, raw_z, two's complement words) enters
// on smp; one result item leaves on res for each sample. Register calib_enable
// sits at byte address 0 of the APB port. While it is 1, each sample only
// updates the per-axis min/max bounds (the first sample after a write of 1
// reloads them) and the result carries in_calibration = 1 and zero norms.
// While it is 0, each axis is (raw - center) / (max - min) in Q.FRAC_BITS,
// rounded half away from zero and saturated to 32 bits; an axis with no span
// gives 0 and raises zero_span.
// Timing: a calibration item skips the divider and goes to the output register
// as soon as that is free. A normalization item runs the three axes through one
// shared restoring divider, one quotient bit per cycle; an axis with no span
// skips the divider. smp.ready is high only while idle, so a new sample is
// taken only once the previous result has entered the output register.
// A finished result waits in the output register while res stalls, and the
// next item can be accepted and computed meanwhile.
// Reset clears the bounds to -0.5 and +0.5 and calib_enable to 0.

module magnetometer_minmax_calibrate_normalize_unit #(
	parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mmc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mmc_smp_if.sink                       smp,
	mmc_res_if.source                     res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mmc_pkg::PADDR_W-1:0]   paddr,
	input  logic [mmc_pkg::PDATA_W-1:0]   pwdata,
	output logic [mmc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	mmc_pkg::cmd_t cmd;
	mmc_pkg::sts_t sts;

	logic calib_q;
	logic first_q;
	logic reg_wr;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == mmc_pkg::REG_CALIB_ENABLE);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (reg_wr && reg_sel) begin
				calib_q <= pwdata[0];
				// a write of 0 leaves the reload flag alone
				if (pwdata[0]) begin
					first_q <= 1'b1;
				end
			end else if (cmd.accept && calib_q) begin
				first_q <= 1'b0;
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = calib_q;
		end
	end

	mmc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (smp.valid),
		.in_ready     (smp.ready),
		.calib_enable (calib_q),
		.sts          (sts),
		.cmd          (cmd)
	);

	mmc_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.calib_enable   (calib_q),
		.first_pending  (first_q),
		.raw_x          (smp.raw_x),
		.raw_y          (smp.raw_y),
		.raw_z          (smp.raw_z),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.norm_x         (res.norm_x),
		.norm_y         (res.norm_y),
		.norm_z         (res.norm_z),
		.in_calibration (res.in_calibration),
		.zero_span      (res.zero_span)
	);

	// One item at a time: the sequencer is busy right after an acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid && smp.ready |=> !smp.ready)
		else $error("sample accepted while previous item in progress");

	// Calibration results carry zero norms and no span flag
	a_calib_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.in_calibration |->
			res.norm_x == 32'sd0 && res.norm_y == 32'sd0 && res.norm_z == 32'sd0
			&& !res.zero_span)
		else $error("calibration result with nonzero payload");

	// Writing 1 to calib_enable arms the first-sample reload
	a_arm_reload: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr && reg_sel && pwdata[0] |=> first_q && calib_q)
		else $error("reload not armed after enable write");

endmodule

// ----- rtl/mmc_ctrl.sv -----
// Sequencer of the calibration block: accepts an item, walks the three axes of
// a normalization item through setup, divide (none at zero span) and store,
// then hands the result to the output register. Uses mmc_pkg cmd/sts types.

module mmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          calib_enable,
	input  mmc_pkg::sts_t sts,
	output mmc_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_DIV   = 5'b00100,
		S_STORE = 5'b01000,
		S_WAIT  = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] axis_q, axis_d;

	always_comb begin
		state_d     = state_q;
		axis_d      = axis_q;
		cmd         = '0;
		cmd.axis    = axis_q;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					axis_d     = mmc_pkg::AXIS_FIRST;
					// calibration items only move the bounds
					state_d    = calib_enable ? S_WAIT : S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.span_zero ? S_STORE : S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				if (axis_q == mmc_pkg::AXIS_LAST) begin
					state_d = S_WAIT;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_SETUP;
				end
			end
			S_WAIT: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= mmc_pkg::AXIS_FIRST;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

endmodule

// ----- rtl/mmc_dpath.sv -----
// Datapath of the calibration block: sample registers, per-axis bounds,
// a shared restoring divider, rounding and saturation, and the output register.
// Depends on mmc_pkg for the command and status types.

module mmc_dpath #(
	parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mmc_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mmc_pkg::cmd_t          cmd,
	output mmc_pkg::sts_t          sts,
	input  logic                   calib_enable,
	input  logic                   first_pending,
	input  logic [SAMPLE_BITS-1:0] raw_x,
	input  logic [SAMPLE_BITS-1:0] raw_y,
	input  logic [SAMPLE_BITS-1:0] raw_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [31:0]     norm_x,
	output logic signed [31:0]     norm_y,
	output logic signed [31:0]     norm_z,
	output logic                   in_calibration,
	output logic                   zero_span
);

	localparam int HW  = SAMPLE_BITS + 2;      // half-unit sample and bounds
	localparam int NW  = SAMPLE_BITS + 4;      // numerator 2h - min - max
	localparam int MW  = NW - 1;               // numerator magnitude
	localparam int DVW = SAMPLE_BITS + 4;      // divisor 4 * (max - min)
	localparam int NB  = MW + FRAC_BITS + 2;   // dividend and quotient bits
	localparam int CW  = $clog2(NB);
	localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_MAG = 64'h0000_0000_8000_0000;

	logic signed [HW-1:0] h_q  [3];
	logic signed [HW-1:0] mn_q [3];
	logic signed [HW-1:0] mx_q [3];
	logic signed [HW-1:0] h_in [3];

	logic [NB-1:0]   num_q;
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dvs_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic            zero_q;

	logic signed [31:0] acc_q [3];
	logic               cal_acc_q;
	logic               zsp_acc_q;

	logic               out_vld_q;
	logic signed [31:0] out_norm_q [3];
	logic               out_cal_q;
	logic               out_zsp_q;

	// Setup path for the selected axis
	logic signed [HW-1:0] h_sel, mn_sel, mx_sel;
	logic signed [HW:0]   diff;
	logic signed [NW-1:0] n_w;
	logic [NW-1:0]        n_abs;
	logic [DVW-1:0]       d_u;
	logic [DVW-1:0]       dvs_w;
	logic [NB-1:0]        num0;

	// Divider step
	logic [DVW:0]   rs;
	logic           ge;
	logic [DVW:0]   rs_sub;

	// Rounding result
	logic [63:0]        q64;
	logic signed [31:0] q_sat;

	assign h_in[0] = {raw_x[SAMPLE_BITS-1], raw_x, 1'b0};
	assign h_in[1] = {raw_y[SAMPLE_BITS-1], raw_y, 1'b0};
	assign h_in[2] = {raw_z[SAMPLE_BITS-1], raw_z, 1'b0};

	always_comb begin
		h_sel  = h_q[cmd.axis];
		mn_sel = mn_q[cmd.axis];
		mx_sel = mx_q[cmd.axis];
		diff   = {mx_sel[HW-1], mx_sel} - {mn_sel[HW-1], mn_sel};
		n_w    = {h_sel[HW-1], h_sel, 1'b0}
			- {{2{mn_sel[HW-1]}}, mn_sel}
			- {{2{mx_sel[HW-1]}}, mx_sel};
		n_abs  = n_w[NW-1] ? (-n_w) : n_w;
		d_u    = DVW'({diff, 1'b0});
		dvs_w  = DVW'({diff, 2'b00});
		// round half away from zero: (|n| * 2^(F+1) + d) / (2d)
		num0   = NB'({n_abs[MW-1:0], {(FRAC_BITS + 1){1'b0}}}) + NB'(d_u);
	end

	always_comb begin
		rs     = {rem_q, num_q[NB-1]};
		ge     = rs >= {1'b0, dvs_q};
		rs_sub = rs - {1'b0, dvs_q};
	end

	always_comb begin
		q64 = 64'(num_q);
		if (neg_q) begin
			q_sat = (q64 > NEG_MAG) ? 32'sh8000_0000 : 32'(-q64);
		end else begin
			q_sat = (q64 > POS_MAX) ? 32'sh7FFF_FFFF : 32'(q64);
		end
	end

	assign sts.span_zero = diff[HW] || (diff == '0);
	assign sts.div_last  = (cnt_q == '0);
	assign sts.out_free  = !out_vld_q || out_ready;

	// Bounds and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mn_q[i] <= -HW'(1);
				mx_q[i] <= HW'(1);
			end
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.accept && calib_enable) begin
				for (int i = 0; i < 3; i++) begin
					if (first_pending) begin
						mn_q[i] <= h_in[i];
						mx_q[i] <= h_in[i];
					end else begin
						if (h_in[i] > mx_q[i]) begin
							mx_q[i] <= h_in[i];
						end
						if (h_in[i] < mn_q[i]) begin
							mn_q[i] <= h_in[i];
						end
					end
				end
			end
			if (cmd.publish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Working registers and output payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int i = 0; i < 3; i++) begin
				h_q[i]   <= h_in[i];
				acc_q[i] <= '0;
			end
			cal_acc_q <= calib_enable;
			zsp_acc_q <= 1'b0;
		end
		if (cmd.setup) begin
			num_q  <= num0;
			rem_q  <= '0;
			dvs_q  <= dvs_w;
			cnt_q  <= CW'(NB - 1);
			neg_q  <= n_w[NW-1];
			zero_q <= sts.span_zero;
		end
		if (cmd.step) begin
			rem_q <= ge ? rs_sub[DVW-1:0] : rs[DVW-1:0];
			num_q <= {num_q[NB-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.store) begin
			acc_q[cmd.axis] <= zero_q ? 32'sd0 : q_sat;
			if (zero_q) begin
				zsp_acc_q <= 1'b1;
			end
		end
		if (cmd.publish) begin
			for (int i = 0; i < 3; i++) begin
				out_norm_q[i] <= acc_q[i];
			end
			out_cal_q <= cal_acc_q;
			out_zsp_q <= zsp_acc_q;
		end
	end

	assign out_valid      = out_vld_q;
	assign norm_x         = out_norm_q[0];
	assign norm_y         = out_norm_q[1];
	assign norm_z         = out_norm_q[2];
	assign in_calibration = out_cal_q;
	assign zero_span      = out_zsp_q;

endmodule
